### src/rbe_pkg.sv
// ----------------------------------------------------------------------------
// RLE bitmap row encoder package
// Shared constants, symbol codes, types and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rbe_pkg;

   localparam int MAX_COLS   = 4096;
   localparam int MAX_ROWS   = 4096;
   localparam int CFG_W      = 13;
   localparam int POS_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int SYM_W      = 8;
   localparam int BCD_DIGITS = 4;
   localparam int MAX_SYMS   = 8;
   localparam int SLOT_W     = $clog2(MAX_SYMS);
   localparam int CNT_W      = $clog2(MAX_SYMS + 1);
   localparam int Q_DEPTH    = 4;
   localparam int QPTR_W     = $clog2(Q_DEPTH);
   localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_LENGTH = 2'd0,
      CSR_ROW_COUNT  = 2'd1
   } csr_index_type;

   localparam logic [SYM_W-1:0] SYM_ZERO     = 8'h30;
   localparam logic [SYM_W-1:0] SYM_NINE     = 8'h39;
   localparam logic [SYM_W-1:0] SYM_LIVE     = 8'h6F;
   localparam logic [SYM_W-1:0] SYM_DEAD     = 8'h62;
   localparam logic [SYM_W-1:0] SYM_ROW_END  = 8'h24;
   localparam logic [SYM_W-1:0] SYM_NEWLINE  = 8'h0A;
   localparam logic [SYM_W-1:0] SYM_GRID_END = 8'h21;

   typedef logic [BCD_DIGITS-1:0][3:0] bcd_type;
   typedef logic [MAX_SYMS-1:0][SYM_W-1:0] sym_list_type;

   localparam bcd_type BCD_ONE = bcd_type'(16'h0001);

   typedef struct packed {
      sym_list_type     syms;
      logic [CNT_W-1:0] count;
   } job_type;

   function automatic bcd_type bcd_inc(bcd_type v);
      bcd_type r;
      logic carry;
      r = v;
      carry = 1'b1;
      for (int k = 0; k < BCD_DIGITS; k++) begin
         if (carry) begin
            if (r[k] == 4'd9) begin
               r[k] = 4'd0;
            end else begin
               r[k] = r[k] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [2:0] bcd_len(bcd_type v);
      logic [2:0] n;
      if (v[3] != 4'd0) begin
         n = 3'd4;
      end else if (v[2] != 4'd0) begin
         n = 3'd3;
      end else if (v[1] != 4'd0) begin
         n = 3'd2;
      end else begin
         n = 3'd1;
      end
      return n;
   endfunction

   function automatic logic [POS_W-1:0] last_index(logic [CFG_W-1:0] v, int cap);
      logic [CFG_W-1:0] m;
      if (v == '0) begin
         m = '0;
      end else if (v > CFG_W'(cap)) begin
         m = CFG_W'(cap - 1);
      end else begin
         m = v - CFG_W'(1);
      end
      return m[POS_W-1:0];
   endfunction

endpackage

`default_nettype wire

### src/rbe_front.sv
// ----------------------------------------------------------------------------
// RLE bitmap row encoder front end
// Accepts cell beats, tracks the open run and grid position, holds the
// grid size registers and turns each beat into a list of symbols.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_front import rbe_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_cell_req,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data,
   input  wire logic                 q_full,
   output logic                      q_push,
   output job_type                   q_job
);

   logic             run_value_ff, run_value_in;
   logic             run_active_ff, run_active_in;
   bcd_type          run_bcd_ff, run_bcd_in;
   logic [POS_W-1:0] column_ff, column_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [POS_W-1:0] last_col_ff, last_col_in;
   logic [POS_W-1:0] last_row_ff, last_row_in;

   logic    accept;
   logic    changed;
   logic    row_end;
   logic    grid_end;
   logic    cfg_hit;
   bcd_type new_bcd;
   job_type job;

   function automatic job_type append_sym(job_type j, logic [SYM_W-1:0] s);
      job_type r;
      r = j;
      r.syms[r.count[SLOT_W-1:0]] = s;
      r.count = r.count + CNT_W'(1);
      return r;
   endfunction

   function automatic job_type append_run(job_type j, bcd_type len, logic val);
      job_type    r;
      logic [2:0] nd;
      r = j;
      nd = bcd_len(len);
      if (len != BCD_ONE) begin
         for (int k = BCD_DIGITS - 1; k >= 0; k--) begin
            if (3'(k) < nd) begin
               r = append_sym(r, SYM_ZERO + {4'd0, len[k]});
            end
         end
      end
      r = append_sym(r, val ? SYM_LIVE : SYM_DEAD);
      return r;
   endfunction

   assign req_stall = q_full || cfg_hit;
   assign accept    = req_valid && !req_stall;
   assign changed   = run_active_ff && (req_cell_req != run_value_ff);
   assign row_end   = (column_ff == last_col_ff);
   assign grid_end  = (row_ff == last_row_ff);
   assign new_bcd   = (changed || !run_active_ff) ? BCD_ONE : bcd_inc(run_bcd_ff);
   assign cfg_hit   = csr_valid && ((csr_index == CSR_ROW_LENGTH) ||
                                    (csr_index == CSR_ROW_COUNT));

   always_comb begin
      job = '0;
      if (changed) begin
         job = append_run(job, run_bcd_ff, run_value_ff);
      end
      if (row_end) begin
         job = append_run(job, new_bcd, req_cell_req);
         if (grid_end) begin
            job = append_sym(job, SYM_GRID_END);
         end else begin
            job = append_sym(job, SYM_ROW_END);
            job = append_sym(job, SYM_NEWLINE);
         end
      end
   end

   assign q_job  = job;
   assign q_push = accept && !cfg_hit && (job.count != '0);

   always_comb begin
      run_value_in  = run_value_ff;
      run_active_in = run_active_ff;
      run_bcd_in    = run_bcd_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      last_col_in   = last_col_ff;
      last_row_in   = last_row_ff;
      if (cfg_hit) begin
         run_value_in  = 1'b0;
         run_active_in = 1'b0;
         column_in     = '0;
         row_in        = '0;
         if (csr_index == CSR_ROW_LENGTH) begin
            last_col_in = last_index(csr_data, MAX_COLS);
         end else begin
            last_row_in = last_index(csr_data, MAX_ROWS);
         end
      end else if (accept) begin
         run_value_in = req_cell_req;
         if (row_end) begin
            run_active_in = 1'b0;
            column_in     = '0;
            row_in        = grid_end ? '0 : row_ff + POS_W'(1);
         end else begin
            run_active_in = 1'b1;
            run_bcd_in    = new_bcd;
            column_in     = column_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff  <= 1'b0;
         run_active_ff <= 1'b0;
         column_ff     <= '0;
         row_ff        <= '0;
         last_col_ff   <= '0;
         last_row_ff   <= '0;
      end else begin
         run_value_ff  <= run_value_in;
         run_active_ff <= run_active_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         last_col_ff   <= last_col_in;
         last_row_ff   <= last_row_in;
      end
   end

   always_ff @(posedge clock) begin
      run_bcd_ff <= run_bcd_in;
   end

endmodule

`default_nettype wire

### src/rbe_queue.sv
// ----------------------------------------------------------------------------
// RLE bitmap row encoder symbol list queue
// A short FIFO of symbol lists between the front end and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_queue import rbe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   output logic         head_valid,
   output job_type      head_job,
   input  wire logic    pop
);

   job_type           entry_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### src/rbe_back.sv
// ----------------------------------------------------------------------------
// RLE bitmap row encoder emitter
// Walks the symbol list at the queue head and sends one symbol per beat
// through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_back import rbe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire job_type head_job,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [SYM_W-1:0] rsp_symbol,
   output logic         rsp_last
);

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [SYM_W-1:0]  symbol_ff, symbol_in;
   logic              last_ff, last_in;
   logic              take;
   logic              at_end;

   assign take   = head_valid && (!valid_ff || !rsp_stall);
   assign at_end = ((CNT_W'(idx_ff) + CNT_W'(1)) == head_job.count);
   assign pop    = take && at_end;

   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff && rsp_stall;
      symbol_in = symbol_ff;
      last_in   = last_ff;
      if (take) begin
         valid_in  = 1'b1;
         symbol_in = head_job.syms[idx_ff];
         last_in   = at_end;
         idx_in    = at_end ? '0 : idx_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff <= symbol_in;
      last_ff   <= last_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_symbol = symbol_ff;
   assign rsp_last   = last_ff;

endmodule

`default_nettype wire

### src/rle_bitmap_row_encoder_top.sv
// The first symbol of a beat is written into the list queue and then registered in the
// output stage. The cell input takes one beat per cycle while the queue is not full and
// no grid size write is pending; the output sends one symbol per cycle while not stalled.
// A four-entry list queue decouples the cell input from the symbol output.
// Reset clears the run and position, sets a 1 by 1 grid and empties the queue.
// ----------------------------------------------------------------------------
// RLE bitmap row encoder top level
// Encodes a row-major cell bit stream as the body of a Life RLE pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_bitmap_row_encoder_top import rbe_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_cell_req,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [SYM_W-1:0]          rsp_symbol,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data
);

   logic    q_full;
   logic    q_push;
   job_type q_job;
   logic    head_valid;
   job_type head_job;
   logic    q_pop;

   assign csr_ready = 1'b1;

   rbe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cell_req (req_cell_req),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_job        (q_job)
   );

   rbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (q_pop)
   );

   rbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

endmodule

`default_nettype wire

### src/rbe_checker.sv
// ----------------------------------------------------------------------------
// RLE bitmap row encoder port checker
// Checks the symbol stream seen on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_checker import rbe_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [SYM_W-1:0] rsp_symbol,
   input wire logic             rsp_last
);

   logic is_digit;

   assign is_digit = (rsp_symbol >= SYM_ZERO) && (rsp_symbol <= SYM_NINE);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Stalled beat was dropped.");

   a_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> is_digit || rsp_symbol == SYM_LIVE || rsp_symbol == SYM_DEAD ||
                    rsp_symbol == SYM_ROW_END || rsp_symbol == SYM_NEWLINE ||
                    rsp_symbol == SYM_GRID_END)
      else $error("Illegal symbol on output.");

   a_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_symbol == SYM_ROW_END |=>
         rsp_valid && rsp_symbol == SYM_NEWLINE)
      else $error("Row end was not followed by a newline.");

   a_term_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_symbol == SYM_NEWLINE || rsp_symbol == SYM_GRID_END) |-> rsp_last)
      else $error("Row or grid end did not close the beat's symbols.");

   a_digit_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (is_digit || rsp_symbol == SYM_ROW_END) |-> !rsp_last)
      else $error("Symbol list ended on a digit or row end.");

endmodule

bind rle_bitmap_row_encoder_top rbe_checker u_rbe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_symbol (rsp_symbol),
   .rsp_last   (rsp_last)
);

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RLE bitmap row encoder testbench
// Streams cell bits into the encoder under several grid sizes and handshake
// patterns, predicts the output symbols in a local encoder or takes them from typed
// text, and compares each symbol beat in order, including a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import rbe_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_3 = 2'd3;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } sym_beat_type;

   typedef enum bit {STEP_CELL, STEP_CSR} step_kind_type;

   typedef struct {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     data;
      bit                   cell_bit;
      bit                   typed;
      string                text;
   } plan_step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_cell_req = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [SYM_W-1:0]     rsp_symbol;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   sym_beat_type pending_syms[$];
   sym_beat_type fresh_syms[$];
   sym_beat_type head_beat;
   int           mismatch_count = 0;
   int           sender_idle_pct = 0;
   int           receiver_idle_pct = 0;
   bit           pressure_armed = 1'b0;
   bit           hold_taken = 1'b0;
   int           hold_left = 0;

   logic [CFG_W-1:0] grid_row_length = 13'd1;
   logic [CFG_W-1:0] grid_row_count = 13'd1;
   logic             enc_run_value = 1'b0;
   logic [CFG_W-1:0] enc_run_length = '0;
   logic [POS_W-1:0] enc_column = '0;
   logic [POS_W-1:0] enc_row = '0;

   plan_step_type directed_plan[$] = '{
      '{STEP_CELL, '0, '0, 1'b1, 1'b1, "o!"},
      '{STEP_CELL, '0, '0, 1'b0, 1'b1, "b!"},
      '{STEP_CSR, CSR_UNUSED_2, 13'd5, 1'b0, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b1, 1'b1, "o!"},
      '{STEP_CSR, CSR_UNUSED_3, 13'd8191, 1'b0, 1'b0, ""},
      '{STEP_CSR, CSR_ROW_LENGTH, 13'd0, 1'b0, 1'b0, ""},
      '{STEP_CSR, CSR_ROW_COUNT, 13'd0, 1'b0, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b0, 1'b1, "b!"},
      '{STEP_CSR, CSR_ROW_LENGTH, 13'd3, 1'b0, 1'b0, ""},
      '{STEP_CSR, CSR_ROW_COUNT, 13'd2, 1'b0, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b1, 1'b1, ""},
      '{STEP_CELL, '0, '0, 1'b1, 1'b1, ""},
      '{STEP_CELL, '0, '0, 1'b1, 1'b1, "3o$\n"},
      '{STEP_CELL, '0, '0, 1'b0, 1'b1, ""},
      '{STEP_CELL, '0, '0, 1'b1, 1'b1, "b"},
      '{STEP_CELL, '0, '0, 1'b0, 1'b1, "ob!"},
      '{STEP_CSR, CSR_ROW_LENGTH, 13'd4, 1'b0, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b1, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b1, 1'b0, ""},
      '{STEP_CSR, CSR_UNUSED_2, 13'd8191, 1'b0, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b0, 1'b0, ""},
      '{STEP_CSR, CSR_ROW_COUNT, 13'd8191, 1'b0, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b0, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b0, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b1, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b0, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b1, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b1, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b1, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b0, 1'b0, ""},
      '{STEP_CELL, '0, '0, 1'b0, 1'b0, ""}
   };

   rle_bitmap_row_encoder_top uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cell_req (req_cell_req),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_symbol   (rsp_symbol),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int grid_extent(logic [CFG_W-1:0] value, int cap);
      if (value == '0) begin
         return 1;
      end
      if (int'(value) > cap) begin
         return cap;
      end
      return int'(value);
   endfunction

   function automatic void add_fresh(logic [SYM_W-1:0] symbol);
      sym_beat_type beat;
      beat.symbol = symbol;
      beat.last = 1'b0;
      fresh_syms.insert(fresh_syms.size(), beat);
   endfunction

   function automatic void emit_run(int run_len, logic run_val);
      int  divisor;
      int  digit;
      bit  started;
      started = 1'b0;
      if (run_len > 1) begin
         for (divisor = 1000; divisor > 0; divisor = divisor / 10) begin
            digit = (run_len / divisor) % 10;
            if (digit != 0 || started || divisor == 1) begin
               add_fresh(SYM_ZERO + SYM_W'(digit));
               started = 1'b1;
            end
         end
      end
      add_fresh(run_val ? SYM_LIVE : SYM_DEAD);
   endfunction

   function automatic void encode_cell(logic cell_bit);
      int width;
      int height;
      width = grid_extent(grid_row_length, MAX_COLS);
      height = grid_extent(grid_row_count, MAX_ROWS);
      fresh_syms.delete();
      if (enc_run_length != '0 && cell_bit != enc_run_value) begin
         emit_run(int'(enc_run_length), enc_run_value);
         enc_run_length = '0;
      end
      enc_run_value = cell_bit;
      enc_run_length = enc_run_length + CFG_W'(1);
      if (int'(enc_column) + 1 >= width) begin
         emit_run(int'(enc_run_length), enc_run_value);
         enc_run_length = '0;
         enc_column = '0;
         if (int'(enc_row) + 1 >= height) begin
            add_fresh(SYM_GRID_END);
            enc_row = '0;
         end else begin
            add_fresh(SYM_ROW_END);
            add_fresh(SYM_NEWLINE);
            enc_row = enc_row + POS_W'(1);
         end
      end else begin
         enc_column = enc_column + POS_W'(1);
      end
      if (fresh_syms.size() > 0) begin
         fresh_syms[fresh_syms.size() - 1].last = 1'b1;
      end
   endfunction

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_syms.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_ROW_LENGTH: grid_row_length = data;
         CSR_ROW_COUNT:  grid_row_count = data;
         default: ;
      endcase
      if (index == CSR_ROW_LENGTH || index == CSR_ROW_COUNT) begin
         enc_run_value = 1'b0;
         enc_run_length = '0;
         enc_column = '0;
         enc_row = '0;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_cell(bit cell_bit, bit typed, string text);
      int           k;
      sym_beat_type beat;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cell_req <= cell_bit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      encode_cell(cell_bit);
      if (typed) begin
         for (k = 0; k < text.len(); k++) begin
            beat.symbol = text[k];
            beat.last = (k == text.len() - 1);
            pending_syms.insert(pending_syms.size(), beat);
         end
      end else begin
         for (k = 0; k < fresh_syms.size(); k++) begin
            pending_syms.insert(pending_syms.size(), fresh_syms[k]);
         end
      end
   endtask

   task automatic shuffle_grid();
      logic [CFG_W-1:0] length_pick;
      logic [CFG_W-1:0] count_pick;
      case ($urandom_range(9))
         0: length_pick = '0;
         1: length_pick = CFG_W'($urandom());
         2, 3: length_pick = CFG_W'($urandom_range(13, 40));
         default: length_pick = CFG_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(9))
         0: count_pick = '0;
         1: count_pick = '1;
         2: count_pick = CFG_W'($urandom());
         default: count_pick = CFG_W'($urandom_range(1, 4));
      endcase
      if ($urandom_range(3) == 0) begin
         csr_write($urandom_range(1) ? CSR_UNUSED_2 : CSR_UNUSED_3, CFG_W'($urandom()));
      end
      csr_write(CSR_ROW_LENGTH, length_pick);
      csr_write(CSR_ROW_COUNT, count_pick);
   endtask

   // The one long hold-off lets the encoder fill its queue and stall the cell input.
   always @(negedge clock) begin
      if (pressure_armed && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_syms.size() == 0) begin
            $error("unexpected symbol beat: symbol %h, last %b", rsp_symbol, rsp_last);
            mismatch_count++;
         end else begin
            head_beat = pending_syms.pop_front();
            if (rsp_symbol !== head_beat.symbol) begin
               $error("symbol: expected %h, actual %h", head_beat.symbol, rsp_symbol);
               mismatch_count++;
            end
            if (rsp_last !== head_beat.last) begin
               $error("last: expected %b, actual %b", head_beat.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #3000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      bit cell_bit;
      int phase;
      cell_bit = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 15;
      receiver_idle_pct = 15;
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_CSR) begin
            csr_write(directed_plan[i].index, directed_plan[i].data);
         end else begin
            send_cell(directed_plan[i].cell_bit, directed_plan[i].typed,
                      directed_plan[i].text);
         end
      end

      // Two-digit runs, and a row end that closes two runs in one beat.
      sender_idle_pct = 0;
      receiver_idle_pct = 65;
      csr_write(CSR_ROW_LENGTH, 13'd11);
      csr_write(CSR_ROW_COUNT, 13'd2);
      repeat (10) send_cell(1'b0, 1'b0, "");
      send_cell(1'b1, 1'b1, "10bo$\n");
      repeat (10) send_cell(1'b1, 1'b0, "");
      send_cell(1'b1, 1'b1, "11o!");

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
            1: begin
               sender_idle_pct = 65;
               receiver_idle_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 65;
            end
            3: begin
               sender_idle_pct = 15;
               receiver_idle_pct = 15;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         if (phase == 4) begin
            csr_write(CSR_ROW_LENGTH, 13'd2);
            csr_write(CSR_ROW_COUNT, 13'd3);
            pressure_armed = 1'b1;
         end else begin
            shuffle_grid();
         end
         repeat (21) begin
            if (phase != 4 && $urandom_range(14) == 0) begin
               shuffle_grid();
            end
            if ($urandom_range(99) < 35) begin
               cell_bit = ~cell_bit;
            end
            send_cell(cell_bit, 1'b0, "");
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

### rle_bitmap_row_encoder_top.f
src/rbe_pkg.sv
src/rbe_front.sv
src/rbe_queue.sv
src/rbe_back.sv
src/rle_bitmap_row_encoder_top.sv
src/rbe_checker.sv
verif/testbench.sv
